### sv/binary_trie_prefix_lookup_assert.svh
// Assertion macros shared by the lookup block.
`ifndef BINARY_TRIE_PREFIX_LOOKUP_ASSERT_SVH
`define BINARY_TRIE_PREFIX_LOOKUP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BTPL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("binary_trie_prefix_lookup: check failed");

// Next-cycle implication, disabled during reset.
`define BTPL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("binary_trie_prefix_lookup: check failed");

`endif

### sv/btpl_pkg.sv
package btpl_pkg;

  // Default number of tree nodes held in the node memory.
  localparam int unsigned TREE_NODES_DEF = 65536;

  // Fixed field widths.
  localparam int unsigned REC_W    = 24;
  localparam int unsigned NC_W     = 17;
  localparam int unsigned IDX_W    = 16;
  localparam int unsigned ADDR_W   = 128;
  localparam int unsigned DEPTH_W  = 7;
  localparam int unsigned STATUS_W = 2;
  // Width used for compares against the node store size (up to 2**24).
  localparam int unsigned WIDE_W   = 25;
  localparam int unsigned SEPARATOR_BYTES = 16;

  // Command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = 1;

  // Request operations.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_WRITE_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ENTRY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MALFORMED  = 2'd3;

  // Command kinds after classification.
  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_SKIP   = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  typedef struct packed {
    logic              operation;
    logic [IDX_W-1:0]  node_index;
    logic [REC_W-1:0]  left_record;
    logic [REC_W-1:0]  right_record;
    logic [63:0]       addr_high;
    logic [63:0]       addr_low;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [REC_W-1:0]    data_offset;
  } rsp_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [IDX_W-1:0]  node_index;
    logic [REC_W-1:0]  left_record;
    logic [REC_W-1:0]  right_record;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic               walking;
    logic [DEPTH_W-1:0] depth;
  } back_stat_t;

endpackage

### sv/btpl_queue.sv
module btpl_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  btpl_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output btpl_pkg::cmd_t pop_data
);

  localparam int unsigned CNT_W = btpl_pkg::QUEUE_AW + 1;

  btpl_pkg::cmd_t                   entries [btpl_pkg::QUEUE_DEPTH];
  logic [btpl_pkg::QUEUE_AW-1:0]    wr_ptr;
  logic [btpl_pkg::QUEUE_AW-1:0]    rd_ptr;
  logic [CNT_W-1:0]                 count;

  assign full      = (count == CNT_W'(btpl_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

### sv/btpl_front.sv
module btpl_front #(
  parameter int unsigned TREE_NODES = btpl_pkg::TREE_NODES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  btpl_pkg::req_t req,
  output logic           cmd_valid,
  input  logic           cmd_pop,
  output btpl_pkg::cmd_t cmd
);

  localparam logic [btpl_pkg::WIDE_W-1:0] NODES_W = btpl_pkg::WIDE_W'(TREE_NODES);

  btpl_pkg::cmd_t               cmd_in;
  logic                         q_full;
  logic [btpl_pkg::WIDE_W-1:0]  idx_wide;

  // Classify the request: writes outside the store are kept only for their result.
  always_comb begin
    idx_wide            = {{(btpl_pkg::WIDE_W - btpl_pkg::IDX_W){1'b0}}, req.node_index};
    cmd_in.node_index   = req.node_index;
    cmd_in.left_record  = req.left_record;
    cmd_in.right_record = req.right_record;
    cmd_in.addr         = {req.addr_high, req.addr_low};
    if (req.operation == btpl_pkg::OP_LOOKUP) begin
      cmd_in.kind = btpl_pkg::CMD_LOOKUP;
    end else if (idx_wide < NODES_W) begin
      cmd_in.kind = btpl_pkg::CMD_WRITE;
    end else begin
      cmd_in.kind = btpl_pkg::CMD_SKIP;
    end
  end

  assign req_ready = !q_full;

  btpl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (req_valid && req_ready),
    .push_data (cmd_in),
    .full      (q_full),
    .pop       (cmd_pop),
    .not_empty (cmd_valid),
    .pop_data  (cmd)
  );

endmodule

### sv/btpl_back.sv
module btpl_back #(
  parameter int unsigned TREE_NODES = btpl_pkg::TREE_NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [btpl_pkg::NC_W-1:0]   node_total,
  input  logic                        cmd_valid,
  output logic                        cmd_pop,
  input  btpl_pkg::cmd_t              cmd,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output btpl_pkg::rsp_t              rsp,
  output btpl_pkg::back_stat_t        stat
);

  localparam int unsigned NODE_AW = (TREE_NODES > 1) ? $clog2(TREE_NODES) : 1;
  localparam int unsigned W  = btpl_pkg::WIDE_W;
  localparam int unsigned RW = btpl_pkg::REC_W;
  localparam logic [W-1:0] NODES_W = W'(TREE_NODES);
  localparam logic [btpl_pkg::DEPTH_W-1:0] DEPTH_LAST =
    btpl_pkg::DEPTH_W'(btpl_pkg::ADDR_W - 1);
  localparam logic [RW-1:0] SEP = RW'(btpl_pkg::SEPARATOR_BYTES);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_REDUCE = 2'd2;

  logic [1:0]                    state;
  logic [1:0]                    state_next;
  logic [btpl_pkg::DEPTH_W-1:0]  depth;
  logic [btpl_pkg::ADDR_W-1:0]   addr_sh;
  logic [btpl_pkg::NC_W-1:0]     red;
  logic [btpl_pkg::NC_W-1:0]     red_next;
  btpl_pkg::rsp_t                rsp_q;

  logic [2*RW-1:0]   tree_mem [TREE_NODES];
  logic [2*RW-1:0]   rdata;
  logic [NODE_AW-1:0] raddr;
  logic [NODE_AW-1:0] waddr;
  logic [2*RW-1:0]   wdata;
  logic              we;

  logic              slot_free;
  logic              load_res;
  btpl_pkg::rsp_t    res;
  logic              start;
  logic              step;
  logic [RW-1:0]     rec;
  logic [RW-1:0]     nc_ext;
  logic [RW-1:0]     diff;
  logic [W-1:0]      next_wide;
  logic [W-1:0]      red_wide;
  logic [W-1:0]      idx_wide;

  // Record selection and compares against the node count.
  always_comb begin
    rec       = addr_sh[btpl_pkg::ADDR_W-1] ? rdata[RW-1:0] : rdata[2*RW-1:RW];
    nc_ext    = {{(RW - btpl_pkg::NC_W){1'b0}}, node_total};
    diff      = rec - nc_ext;
    next_wide = {{(W - btpl_pkg::NC_W){1'b0}}, rec[btpl_pkg::NC_W-1:0]};
    red_wide  = {{(W - btpl_pkg::NC_W){1'b0}}, red};
    idx_wide  = {{(W - btpl_pkg::IDX_W){1'b0}}, cmd.node_index};
    waddr     = idx_wide[NODE_AW-1:0];
    wdata     = {cmd.left_record, cmd.right_record};
  end

  assign slot_free = !rsp_valid || rsp_ready;

  // Walk sequencer: one node read per cycle outside reduce, one bit per step.
  always_comb begin
    state_next = state;
    red_next   = red;
    cmd_pop    = 1'b0;
    we         = 1'b0;
    load_res   = 1'b0;
    res        = '0;
    raddr      = '0;
    start      = 1'b0;
    step       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && slot_free) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            btpl_pkg::CMD_WRITE: begin
              we         = 1'b1;
              load_res   = 1'b1;
              res.status = btpl_pkg::ST_WRITE_DONE;
            end
            btpl_pkg::CMD_LOOKUP: begin
              start      = 1'b1;
              state_next = S_WALK;
            end
            default: begin
              load_res   = 1'b1;
              res.status = btpl_pkg::ST_WRITE_DONE;
            end
          endcase
        end
      end
      S_WALK: begin
        priority if (rec == nc_ext) begin
          load_res   = 1'b1;
          res.status = btpl_pkg::ST_NO_ENTRY;
          state_next = S_IDLE;
        end else if (rec > nc_ext) begin
          load_res = 1'b1;
          if (diff < SEP) begin
            res.status = btpl_pkg::ST_MALFORMED;
          end else begin
            res.status      = btpl_pkg::ST_FOUND;
            res.data_offset = diff - SEP;
          end
          state_next = S_IDLE;
        end else if (depth == DEPTH_LAST) begin
          load_res   = 1'b1;
          res.status = btpl_pkg::ST_NO_ENTRY;
          state_next = S_IDLE;
        end else if (next_wide >= NODES_W) begin
          red_next   = rec[btpl_pkg::NC_W-1:0];
          state_next = S_REDUCE;
        end else begin
          raddr = next_wide[NODE_AW-1:0];
          step  = 1'b1;
        end
      end
      S_REDUCE: begin
        // A record past the store wraps around it, one subtraction per cycle.
        if (red_wide >= NODES_W) begin
          red_next = btpl_pkg::NC_W'(red_wide - NODES_W);
        end else begin
          raddr      = red_wide[NODE_AW-1:0];
          step       = 1'b1;
          state_next = S_WALK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (start) begin
        depth <= '0;
      end else if (step) begin
        depth <= depth + 1'b1;
      end
      if (load_res) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    red <= red_next;
    if (start) begin
      addr_sh <= cmd.addr;
    end else if (step) begin
      addr_sh <= {addr_sh[btpl_pkg::ADDR_W-2:0], 1'b0};
    end
    if (load_res) begin
      rsp_q <= res;
    end
  end

  // Node memory with registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      tree_mem[waddr] <= wdata;
    end
    rdata <= tree_mem[raddr];
  end

  assign rsp          = rsp_q;
  assign stat.walking = (state != S_IDLE);
  assign stat.depth   = depth;

endmodule

### sv/binary_trie_prefix_lookup.sv
// Longest-prefix lookup over a binary trie of 24-bit record pairs.
// Request channel (req_valid/req_ready/req): one beat is either a node write
// (operation 0) that loads both records of one node, or a lookup (operation 1)
// of a 128-bit address, walked from its most significant bit at node 0.
// Response channel (rsp_valid/rsp_ready/rsp): exactly one beat per request,
// in request order, carrying a status and the data offset.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes node_total; always
// ready. The user must have it written only while no request is in flight;
// the block itself does not enforce this. A lookup reads k nodes (1 to 128),
// one per address bit from node 0; a record past the store first goes to the
// reduce state, which subtracts the store size until the record falls inside.
// The walk is bound by the single read port of the node memory: one node per
// cycle while no record wraps. The walker takes no new command until a lookup
// ends; a two-entry queue takes further requests while a walk runs.
// Reset clears node_total to 0 and empties the queue and response register;
// the node memory is not cleared, and nodes must be written before use.
// When the receiver stalls, the response register holds its beat, the walker
// waits, and requests back up into the queue until req_ready drops.
module binary_trie_prefix_lookup #(
  parameter int unsigned TREE_NODES = btpl_pkg::TREE_NODES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  btpl_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output btpl_pkg::rsp_t             rsp,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [btpl_pkg::NC_W-1:0]  cfg_data
);

`include "binary_trie_prefix_lookup_assert.svh"

  logic [btpl_pkg::NC_W-1:0] node_total;
  logic                      cmd_valid;
  logic                      cmd_pop;
  btpl_pkg::cmd_t            cmd;
  btpl_pkg::back_stat_t      stat;

  // Node count register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      node_total <= '0;
    end else if (cfg_valid && cfg_ready) begin
      node_total <= cfg_data;
    end
  end

  btpl_front #(
    .TREE_NODES (TREE_NODES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  btpl_back #(
    .TREE_NODES (TREE_NODES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .node_total (node_total),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .cmd        (cmd),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .stat       (stat)
  );

  // While a walk runs, the response register is empty.
  `BTPL_ASSERT_IMP(a_walk_no_rsp, clk, rst, stat.walking, !rsp_valid)
  // Every walk starts at the first address bit.
  `BTPL_ASSERT_IMP(a_walk_start, clk, rst, $rose(stat.walking), stat.depth == '0)
  // Only a found entry carries a data offset.
  `BTPL_ASSERT_IMP(a_offset_zero, clk, rst,
                   rsp_valid && (rsp.status != btpl_pkg::ST_FOUND),
                   rsp.data_offset == '0)
  // Nothing is popped from the queue during a walk.
  `BTPL_ASSERT_IMP(a_no_pop_walk, clk, rst, stat.walking, !cmd_pop)

endmodule

### test/binary_trie_prefix_lookup_test.sv
`timescale 1ns / 100ps

module binary_trie_prefix_lookup_test;
  import btpl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned DIRECTED_ROWS = 27;

  // One directed beat, optionally preceded by a node count write.
  typedef struct packed {
    bit              cfg_write;
    logic [NC_W-1:0] cfg_value;
    req_t            item;
    bit              typed;
    rsp_t            typed_rsp;
  } directed_row_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            req_valid = 1'b0;
  logic            req_ready;
  req_t            req = '0;
  logic            rsp_valid;
  logic            rsp_ready = 1'b0;
  rsp_t            rsp;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [NC_W-1:0] cfg_data = '0;

  // Trie mirror used to predict every response that a directed row does not give.
  bit [2*REC_W-1:0] node_store [TREE_NODES_DEF];
  bit               node_written [TREE_NODES_DEF];
  int unsigned      node_total_model = 0;

  rsp_t          expected_rsps [$];
  rsp_t          awaited_rsp;
  directed_row_t directed_rows [DIRECTED_ROWS];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   items_sent = 0;
  int unsigned   stall_left = 0;
  bit            tx_burst = 1'b0;
  bit            rx_burst = 1'b0;

  binary_trie_prefix_lookup DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Walk the mirrored trie from the top address bit; flags any read of a
  // node that was never loaded.
  function automatic rsp_t walk_trie(input logic [ADDR_W-1:0] addr, output bit unsafe);
    rsp_t             result;
    logic [IDX_W-1:0] node;
    int unsigned      rec;
    result.status = ST_NO_ENTRY;
    result.data_offset = '0;
    unsafe = 1'b0;
    node = '0;
    for (int k = ADDR_W - 1; k >= 0; k--) begin
      if (!node_written[node]) unsafe = 1'b1;
      rec = 32'(addr[k] ? node_store[node][REC_W-1:0]
                        : node_store[node][2*REC_W-1:REC_W]);
      if (rec == node_total_model) break;
      if (rec > node_total_model) begin
        if (rec - node_total_model < SEPARATOR_BYTES) begin
          result.status = ST_MALFORMED;
        end else begin
          result.status = ST_FOUND;
          result.data_offset = REC_W'(rec - node_total_model - SEPARATOR_BYTES);
        end
        break;
      end
      node = IDX_W'(rec % TREE_NODES_DEF);
    end
    return result;
  endfunction

  // Apply one request beat to the mirror and return its response.
  function automatic rsp_t trie_step(input req_t item);
    rsp_t result;
    bit   unsafe;
    if (item.operation == OP_WRITE) begin
      node_store[item.node_index] = {item.left_record, item.right_record};
      node_written[item.node_index] = 1'b1;
      result.status = ST_WRITE_DONE;
      result.data_offset = '0;
    end else begin
      result = walk_trie({item.addr_high, item.addr_low}, unsafe);
    end
    return result;
  endfunction

  // Unused fields of each request kind carry random content.
  function automatic req_t node_write(input logic [IDX_W-1:0] index,
                                      input logic [REC_W-1:0] left,
                                      input logic [REC_W-1:0] right);
    req_t item;
    item.operation = OP_WRITE;
    item.node_index = index;
    item.left_record = left;
    item.right_record = right;
    item.addr_high = {$urandom, $urandom};
    item.addr_low = {$urandom, $urandom};
    return item;
  endfunction

  function automatic req_t lookup_item(input logic [63:0] high, input logic [63:0] low);
    req_t item;
    item.operation = OP_LOOKUP;
    item.node_index = IDX_W'($urandom);
    item.left_record = REC_W'($urandom);
    item.right_record = REC_W'($urandom);
    item.addr_high = high;
    item.addr_low = low;
    return item;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A record that either points at a node loaded in this phase (possibly
  // through the wrap past the store) or ends the walk in one of its ways.
  function automatic logic [REC_W-1:0] pick_record(input int unsigned count,
                                                   input int unsigned span,
                                                   input int unsigned ptr_pct);
    int unsigned targets;
    int unsigned target;
    targets = (count < span) ? count : span;
    if (targets != 0 && $urandom_range(0, 99) < ptr_pct) begin
      target = $urandom_range(0, targets - 1);
      if (count > TREE_NODES_DEF + target && $urandom_range(0, 1) == 1)
        target += TREE_NODES_DEF;
      return REC_W'(target);
    end
    case ($urandom_range(0, 3))
      0: return REC_W'(count);
      1: return REC_W'(count + $urandom_range(1, 15));
      2: return REC_W'(count + SEPARATOR_BYTES + $urandom_range(0, 255));
      default: return REC_W'($urandom_range(count + SEPARATOR_BYTES, 24'hFF_FFFF));
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return {64{2'($urandom)}};
      default: return {$urandom, $urandom, $urandom, $urandom};
    endcase
  endfunction

  task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: expected status %0d offset 0x%06h, got status %0d offset 0x%06h",
               what, want.status, want.data_offset, got.status, got.data_offset);
  endtask

  // Present one request beat, hold it until accepted, then maybe idle.
  task automatic send_item(input req_t item, input bit typed, input rsp_t typed_rsp);
    rsp_t        predicted;
    int unsigned gap;
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted = trie_step(item);
    expected_rsps.push_back(typed ? typed_rsp : predicted);
    items_sent++;
    if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : idle_len();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // The node count is only changed once every response is back.
  task automatic set_node_count(input logic [NC_W-1:0] value);
    req_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    node_total_model = 32'(value);
  endtask

  // Load nodes 0..span-1, then mostly lookups with some node rewrites and
  // some writes to nodes the walk never reaches.
  task automatic run_trie_phase(input int unsigned count, input int unsigned span,
                                input int unsigned n_items, input int unsigned ptr_pct);
    req_t              item;
    logic [ADDR_W-1:0] addr;
    bit                unsafe;
    int unsigned       tries;
    int unsigned       pick;
    set_node_count(NC_W'(count));
    for (int unsigned i = 0; i < span; i++)
      send_item(node_write(IDX_W'(i), pick_record(count, span, ptr_pct),
                           pick_record(count, span, ptr_pct)), 1'b0, '0);
    for (int unsigned n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        item = node_write(IDX_W'($urandom_range(0, span - 1)),
                          pick_record(count, span, ptr_pct), pick_record(count, span, ptr_pct));
      end else if (pick < 14) begin
        item = node_write(IDX_W'($urandom_range(span, TREE_NODES_DEF - 1)),
                          REC_W'($urandom), REC_W'($urandom));
      end else begin
        // Never walk into a node that holds nothing yet.
        tries = 0;
        do begin
          addr = pick_address();
          void'(walk_trie(addr, unsafe));
          tries++;
        end while (unsafe && tries < 8);
        if (unsafe)
          item = node_write(IDX_W'(0), pick_record(count, span, ptr_pct),
                            pick_record(count, span, ptr_pct));
        else
          item = lookup_item(addr[ADDR_W-1:64], addr[63:0]);
      end
      send_item(item, 1'b0, '0);
    end
  endtask

  // Check each response beat in order and apply random back-pressure.
  always @(posedge clk) begin
    if (rsp_valid && rsp_ready) begin
      if (expected_rsps.size() == 0) begin
        note_mismatch("response with nothing pending", '0, rsp);
      end else begin
        awaited_rsp = expected_rsps.pop_front();
        if (rsp.status !== awaited_rsp.status || rsp.data_offset !== awaited_rsp.data_offset)
          note_mismatch("response mismatch", awaited_rsp, rsp);
      end
    end
    if ($urandom_range(0, 199) == 0) rx_burst = !rx_burst;
    if (stall_left != 0) begin
      rsp_ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_ready <= 1'b1;
      if (!rx_burst && $urandom_range(0, 5) == 0) stall_left = idle_len();
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int unsigned count;
    int unsigned ptr_pct;
    directed_rows = '{
      // Node count 0 after reset: the root alone decides every lookup.
      '{1'b0, 17'd0, node_write(16'd0, 24'd0, 24'd1), 1'b1, '{ST_WRITE_DONE, 24'd0}},
      '{1'b0, 17'd0, lookup_item('0, '0), 1'b1, '{ST_NO_ENTRY, 24'd0}},
      '{1'b0, 17'd0, lookup_item('1, '1), 1'b1, '{ST_MALFORMED, 24'd0}},
      '{1'b0, 17'd0, node_write(16'd0, 24'd16, 24'hFF_FFFF), 1'b1, '{ST_WRITE_DONE, 24'd0}},
      '{1'b0, 17'd0, lookup_item('0, '0), 1'b1, '{ST_FOUND, 24'd0}},
      '{1'b0, 17'd0, lookup_item('1, '1), 1'b1, '{ST_FOUND, 24'hFF_FFEF}},
      '{1'b0, 17'd0, node_write(16'd0, 24'd15, 24'd0), 1'b1, '{ST_WRITE_DONE, 24'd0}},
      '{1'b0, 17'd0, lookup_item('0, '0), 1'b1, '{ST_MALFORMED, 24'd0}},
      // Four nodes: every way a walk can end, and a self loop for too deep.
      '{1'b1, 17'd4, node_write(16'd0, 24'd1, 24'd2), 1'b1, '{ST_WRITE_DONE, 24'd0}},
      '{1'b0, 17'd0, node_write(16'd1, 24'd4, 24'd5), 1'b1, '{ST_WRITE_DONE, 24'd0}},
      '{1'b0, 17'd0, node_write(16'd2, 24'd20, 24'd3), 1'b1, '{ST_WRITE_DONE, 24'd0}},
      '{1'b0, 17'd0, node_write(16'd3, 24'd3, 24'd21), 1'b1, '{ST_WRITE_DONE, 24'd0}},
      '{1'b0, 17'd0, lookup_item('0, '0), 1'b0, '0},
      '{1'b0, 17'd0, lookup_item(64'h4000_0000_0000_0000, '0), 1'b0, '0},
      '{1'b0, 17'd0, lookup_item(64'h8000_0000_0000_0000, '0), 1'b0, '0},
      '{1'b0, 17'd0, lookup_item(64'hC000_0000_0000_0000, '0), 1'b1, '{ST_NO_ENTRY, 24'd0}},
      '{1'b0, 17'd0, lookup_item(64'hC000_0000_0000_0000, 64'd1), 1'b0, '0},
      // Node count above the store: records below it wrap onto low nodes.
      '{1'b1, 17'h1_FFFF, node_write(16'd0, 24'd65537, 24'd131071), 1'b1,
        '{ST_WRITE_DONE, 24'd0}},
      '{1'b0, 17'd0, node_write(16'd1, 24'd131094, 24'd131072), 1'b1, '{ST_WRITE_DONE, 24'd0}},
      '{1'b0, 17'd0, lookup_item('0, '0), 1'b0, '0},
      '{1'b0, 17'd0, lookup_item(64'h4000_0000_0000_0000, '0), 1'b1, '{ST_MALFORMED, 24'd0}},
      '{1'b0, 17'd0, lookup_item('1, '1), 1'b1, '{ST_NO_ENTRY, 24'd0}},
      // Full store: the last node and the largest record.
      '{1'b1, 17'd65536, node_write(16'hFFFF, 24'd65536, 24'hFF_FFFF), 1'b1,
        '{ST_WRITE_DONE, 24'd0}},
      '{1'b0, 17'd0, node_write(16'd0, 24'd65535, 24'd65551), 1'b1, '{ST_WRITE_DONE, 24'd0}},
      '{1'b0, 17'd0, lookup_item(64'h7FFF_FFFF_FFFF_FFFF, '1), 1'b0, '0},
      '{1'b0, 17'd0, lookup_item('0, '0), 1'b0, '0},
      '{1'b0, 17'd0, lookup_item('1, '1), 1'b1, '{ST_MALFORMED, 24'd0}}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_write) set_node_count(directed_rows[i].cfg_value);
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].typed_rsp);
    end

    // Fixed phases at the node count extremes, then random tries.
    run_trie_phase(0, 1, 50, 0);
    run_trie_phase(1, 1, 60, 85);
    run_trie_phase(TREE_NODES_DEF, 24, 150, 90);
    run_trie_phase(131071, 24, 150, 90);
    run_trie_phase(TREE_NODES_DEF - 1, 12, 100, 75);
    while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, TREE_NODES_DEF)
                                          : $urandom_range(0, 48);
      case ($urandom_range(0, 3))
        0: ptr_pct = 40;
        1: ptr_pct = 75;
        2: ptr_pct = 90;
        default: ptr_pct = 100;
      endcase
      run_trie_phase(count, $urandom_range(1, 24), $urandom_range(80, 160), ptr_pct);
    end

    // Drain, then give the block time to show any stray beat.
    req_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/btpl_pkg.sv
sv/btpl_queue.sv
sv/btpl_front.sv
sv/btpl_back.sv
sv/binary_trie_prefix_lookup.sv
test/binary_trie_prefix_lookup_test.sv
